>>> rtl/jts_pkg.sv
// Shared types, character codes and per-byte scanning functions for the JSON token scanner.
`default_nettype none

package jts_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int MAX_EV        = 5;
    localparam int EV_IDX_BITS   = $clog2(MAX_EV + 1);

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_STR     = 4'd1,
        M_ESC     = 4'd2,
        M_HEX     = 4'd3,
        M_INT     = 4'd4,
        M_DOT     = 4'd5,
        M_FRAC    = 4'd6,
        M_EXPMARK = 4'd7,
        M_EXP     = 4'd8,
        M_WORD    = 4'd9
    } mode_t;

    localparam logic [3:0] EV_LBRACE   = 4'd0;
    localparam logic [3:0] EV_RBRACE   = 4'd1;
    localparam logic [3:0] EV_LBRACKET = 4'd2;
    localparam logic [3:0] EV_RBRACKET = 4'd3;
    localparam logic [3:0] EV_COMMA    = 4'd4;
    localparam logic [3:0] EV_COLON    = 4'd5;
    localparam logic [3:0] EV_STR_BYTE = 4'd6;
    localparam logic [3:0] EV_STR_END  = 4'd7;
    localparam logic [3:0] EV_NUM_CHAR = 4'd8;
    localparam logic [3:0] EV_NUM_END  = 4'd9;
    localparam logic [3:0] EV_TRUE     = 4'd10;
    localparam logic [3:0] EV_FALSE    = 4'd11;
    localparam logic [3:0] EV_NULL     = 4'd12;
    localparam logic [3:0] EV_ERROR    = 4'd13;

    localparam logic [7:0] CODE_EOF          = 8'd0;
    localparam logic [7:0] CODE_BAD_HEX      = 8'd1;
    localparam logic [7:0] CODE_UTF16_IGNORE = 8'd2;
    localparam logic [7:0] CODE_BAD_ESCAPE   = 8'd3;
    localparam logic [7:0] CODE_UNTERMINATED = 8'd4;
    localparam logic [7:0] CODE_BAD_CHAR     = 8'd5;
    localparam logic [7:0] CODE_BAD_IDENT    = 8'd6;
    localparam logic [7:0] CODE_NONE         = 8'd0;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_LOW_E    = 8'h65;
    localparam logic [7:0] CH_UP_E     = 8'h45;
    localparam logic [7:0] CH_LOW_B    = 8'h62;
    localparam logic [7:0] CH_LOW_F    = 8'h66;
    localparam logic [7:0] CH_LOW_N    = 8'h6E;
    localparam logic [7:0] CH_LOW_T    = 8'h74;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_LOW_U    = 8'h75;

    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] hex_left;
        logic [7:0] held;
        logic [2:0] flags;
        logic [2:0] wlen;
        logic       wlong;
    } scan_st_t;

    localparam scan_st_t ST_RESET = '{
        mode:     M_IDLE,
        hex_left: 3'd0,
        held:     8'd0,
        flags:    3'b111,
        wlen:     3'd0,
        wlong:    1'b0
    };

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic       nl;
    } ev_t;

    typedef struct packed {
        scan_st_t                   st;
        logic                       nl;
        logic [EV_IDX_BITS-1:0]     n;
        ev_t [MAX_EV-1:0]           ev;
    } work_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    // Keyword letters: candidate 0 is true, 1 is false, 2 is null.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case ({k, pos})
            {2'd0, 3'd0}: c = 8'h74;
            {2'd0, 3'd1}: c = 8'h72;
            {2'd0, 3'd2}: c = 8'h75;
            {2'd0, 3'd3}: c = 8'h65;
            {2'd1, 3'd0}: c = 8'h66;
            {2'd1, 3'd1}: c = 8'h61;
            {2'd1, 3'd2}: c = 8'h6C;
            {2'd1, 3'd3}: c = 8'h73;
            {2'd1, 3'd4}: c = 8'h65;
            {2'd2, 3'd0}: c = 8'h6E;
            {2'd2, 3'd1}: c = 8'h75;
            {2'd2, 3'd2}: c = 8'h6C;
            {2'd2, 3'd3}: c = 8'h6C;
            default:      c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        return (k == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    function automatic work_t emit(input work_t w, input logic [3:0] kind,
                                   input logic [7:0] value);
        work_t r;
        r = w;
        if (r.n < EV_IDX_BITS'(MAX_EV))
        begin
            r.ev[r.n[EV_IDX_BITS-1:0]] = '{kind: kind, value: value, nl: r.nl};
            r.n = r.n + EV_IDX_BITS'(1);
        end
        return r;
    endfunction

    function automatic work_t word_add(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (r.st.wlen >= 3'd5)
        begin
            r.st.wlong = 1'b1;
            r.st.flags = 3'b000;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ((r.st.wlen >= kw_len(2'(k))) || (kw_char(2'(k), r.st.wlen) != b))
                begin
                    r.st.flags[k] = 1'b0;
                end
            end
        end
        if (r.st.wlen < 3'd7)
        begin
            r.st.wlen = r.st.wlen + 3'd1;
        end
        return r;
    endfunction

    function automatic work_t word_finish(input work_t w);
        work_t r;
        r = w;
        r.st.mode = M_IDLE;
        if (r.st.flags[0] && !r.st.wlong && (r.st.wlen == kw_len(2'd0)))
        begin
            r = emit(r, EV_TRUE, CODE_NONE);
        end
        else if (r.st.flags[1] && !r.st.wlong && (r.st.wlen == kw_len(2'd1)))
        begin
            r = emit(r, EV_FALSE, CODE_NONE);
        end
        else if (r.st.flags[2] && !r.st.wlong && (r.st.wlen == kw_len(2'd2)))
        begin
            r = emit(r, EV_NULL, CODE_NONE);
        end
        else
        begin
            r = emit(r, EV_ERROR, CODE_BAD_IDENT);
        end
        return r;
    endfunction

    function automatic work_t scan_idle(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        case (b) inside
            CH_LBRACE:   r = emit(r, EV_LBRACE, CODE_NONE);
            CH_RBRACE:   r = emit(r, EV_RBRACE, CODE_NONE);
            CH_LBRACKET: r = emit(r, EV_LBRACKET, CODE_NONE);
            CH_RBRACKET: r = emit(r, EV_RBRACKET, CODE_NONE);
            CH_COMMA:    r = emit(r, EV_COMMA, CODE_NONE);
            CH_COLON:    r = emit(r, EV_COLON, CODE_NONE);
            CH_SPACE, CH_CR, CH_TAB:
            begin
            end
            CH_LF:       r.nl = 1'b1;
            CH_QUOTE:    r.st.mode = M_STR;
            default:
            begin
                if ((b == CH_MINUS) || is_digit(b))
                begin
                    r = emit(r, EV_NUM_CHAR, b);
                    r.st.mode = M_INT;
                end
                else if (is_alpha(b))
                begin
                    r.st.flags = 3'b111;
                    r.st.wlen  = 3'd0;
                    r.st.wlong = 1'b0;
                    r.st.mode  = M_WORD;
                    r = word_add(r, b);
                end
                else
                begin
                    r = emit(r, EV_ERROR, CODE_BAD_CHAR);
                end
            end
        endcase
        return r;
    endfunction

    function automatic work_t scan_str(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (b == CH_QUOTE)
        begin
            r = emit(r, EV_STR_END, CODE_NONE);
            r.st.mode = M_IDLE;
        end
        else if (b == CH_BSLASH)
        begin
            r.st.mode = M_ESC;
        end
        else
        begin
            r = emit(r, EV_STR_BYTE, b);
        end
        return r;
    endfunction

    // Continues a byte after a refused lookahead; the mode is then idle or word.
    function automatic work_t feed_tail(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (r.st.mode == M_WORD)
        begin
            if (is_alpha(b))
            begin
                r = word_add(r, b);
            end
            else
            begin
                r = word_finish(r);
                r = scan_idle(r, b);
            end
        end
        else
        begin
            r.st.mode = M_IDLE;
            r = scan_idle(r, b);
        end
        return r;
    endfunction

    function automatic work_t feed(input work_t w, input logic [7:0] b);
        work_t      r;
        logic [7:0] h;
        logic [2:0] hl;
        r  = w;
        h  = r.st.held;
        hl = (r.st.hex_left != 3'd0) ? (r.st.hex_left - 3'd1) : r.st.hex_left;
        unique case (r.st.mode)
            M_STR:
            begin
                r = scan_str(r, b);
            end
            M_ESC:
            begin
                r.st.mode = M_STR;
                case (b)
                    CH_QUOTE:  r = emit(r, EV_STR_BYTE, CH_QUOTE);
                    CH_BSLASH: r = emit(r, EV_STR_BYTE, CH_BSLASH);
                    CH_SLASH:  r = emit(r, EV_STR_BYTE, CH_SLASH);
                    CH_LOW_B:  r = emit(r, EV_STR_BYTE, CH_BS);
                    CH_LOW_F:  r = emit(r, EV_STR_BYTE, CH_FF);
                    CH_LOW_N:  r = emit(r, EV_STR_BYTE, CH_LF);
                    CH_LOW_T:  r = emit(r, EV_STR_BYTE, CH_TAB);
                    CH_LOW_R:  r = emit(r, EV_STR_BYTE, CH_CR);
                    CH_LOW_U:
                    begin
                        r.st.mode     = M_HEX;
                        r.st.hex_left = 3'd4;
                    end
                    default:
                    begin
                        r = emit(r, EV_ERROR, CODE_BAD_ESCAPE);
                        r = emit(r, EV_STR_BYTE, b);
                    end
                endcase
            end
            M_HEX:
            begin
                if (is_hex(b))
                begin
                    r.st.hex_left = hl;
                    if (hl == 3'd0)
                    begin
                        r = emit(r, EV_ERROR, CODE_UTF16_IGNORE);
                        r.st.mode = M_STR;
                    end
                end
                else
                begin
                    r = emit(r, EV_ERROR, CODE_BAD_HEX);
                    r = emit(r, EV_ERROR, CODE_UTF16_IGNORE);
                    r.st.hex_left = 3'd0;
                    r.st.mode     = M_STR;
                    r = scan_str(r, b);
                end
            end
            M_INT, M_FRAC:
            begin
                if (is_digit(b))
                begin
                    r = emit(r, EV_NUM_CHAR, b);
                end
                else if ((b == CH_DOT) && (r.st.mode == M_INT))
                begin
                    r.st.held = b;
                    r.st.mode = M_DOT;
                end
                else if ((b == CH_LOW_E) || (b == CH_UP_E))
                begin
                    r.st.held = b;
                    r.st.mode = M_EXPMARK;
                end
                else
                begin
                    r = emit(r, EV_NUM_END, CODE_NONE);
                    r.st.mode = M_IDLE;
                    r = scan_idle(r, b);
                end
            end
            M_DOT, M_EXPMARK:
            begin
                r.st.held = 8'd0;
                if (is_digit(b) ||
                    ((r.st.mode == M_EXPMARK) && ((b == CH_PLUS) || (b == CH_MINUS))))
                begin
                    r = emit(r, EV_NUM_CHAR, h);
                    r = emit(r, EV_NUM_CHAR, b);
                    r.st.mode = (r.st.mode == M_DOT) ? M_FRAC : M_EXP;
                end
                else
                begin
                    r = emit(r, EV_NUM_END, CODE_NONE);
                    r.st.mode = M_IDLE;
                    r = scan_idle(r, h);
                    r = feed_tail(r, b);
                end
            end
            M_EXP:
            begin
                if (is_digit(b))
                begin
                    r = emit(r, EV_NUM_CHAR, b);
                end
                else
                begin
                    r = emit(r, EV_NUM_END, CODE_NONE);
                    r.st.mode = M_IDLE;
                    r = scan_idle(r, b);
                end
            end
            M_WORD:
            begin
                if (is_alpha(b))
                begin
                    r = word_add(r, b);
                end
                else
                begin
                    r = word_finish(r);
                    r = scan_idle(r, b);
                end
            end
            default:
            begin
                r.st.mode = M_IDLE;
                r = scan_idle(r, b);
            end
        endcase
        return r;
    endfunction

    // Closes whatever token is open at the end of the text and adds end of input.
    function automatic work_t flush(input work_t w);
        work_t r;
        r = w;
        unique case (r.st.mode)
            M_STR:
            begin
                r = emit(r, EV_ERROR, CODE_UNTERMINATED);
            end
            M_ESC:
            begin
                r = emit(r, EV_ERROR, CODE_BAD_ESCAPE);
                r = emit(r, EV_ERROR, CODE_UNTERMINATED);
            end
            M_HEX:
            begin
                r = emit(r, EV_ERROR, CODE_BAD_HEX);
                r = emit(r, EV_ERROR, CODE_UTF16_IGNORE);
                r = emit(r, EV_ERROR, CODE_UNTERMINATED);
            end
            M_INT, M_FRAC, M_EXP:
            begin
                r = emit(r, EV_NUM_END, CODE_NONE);
            end
            M_DOT, M_EXPMARK:
            begin
                r = emit(r, EV_NUM_END, CODE_NONE);
                r.st.mode = M_IDLE;
                r = scan_idle(r, r.st.held);
                if (r.st.mode == M_WORD)
                begin
                    r = word_finish(r);
                end
            end
            M_WORD:
            begin
                r = word_finish(r);
            end
            default:
            begin
            end
        endcase
        r = emit(r, EV_ERROR, CODE_EOF);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/json_token_scanner.sv
// Streaming JSON lexer top level: input register, per-byte scan logic and event buffer.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------------
//  in      | in_valid / in_ready  | text_byte, is_final
//  out     | out_valid / out_ready| event_kind, event_value, line_number, last_of_run
//
// A request is registered, scanned in one pass and its events (zero to five) are loaded
// into a five-entry event buffer that sends one event per cycle while out_ready is high.
// A request with events waits until the buffer is empty or its last event is taken.
// Requests that cause no event pass even while the buffer is still draining.
// Reset returns the scanner to idle between tokens with the line count at one.
// A stalled output holds its event; the input register then holds the waiting request.
`default_nettype none

module json_token_scanner #(
    parameter int LINE_BITS = jts_pkg::LINE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        is_final,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       event_kind,
    output logic [7:0]       event_value,
    output logic [15:0]      line_number,
    output logic             last_of_run
);

    import jts_pkg::*;

    logic                    in_valid_reg;
    logic [7:0]              byte_reg;
    logic                    final_reg;
    scan_st_t                st_reg;
    scan_st_t                st_next;
    logic [LINE_BITS-1:0]    line_reg;
    logic [LINE_BITS-1:0]    line_next;
    logic [LINE_BITS-1:0]    line_inc;
    ev_t                     ev_reg [MAX_EV];
    logic [15:0]             ev_line_reg [MAX_EV];
    logic [EV_IDX_BITS-1:0]  cnt_reg;
    logic [EV_IDX_BITS-1:0]  idx_reg;
    work_t                   w_start;
    work_t                   w_fed;
    work_t                   w_done;
    logic                    drain;
    logic                    drain_last;
    logic                    buf_free;
    logic                    move;
    logic [15:0]             line_disp_old;
    logic [15:0]             line_disp_new;

    function automatic logic [15:0] line_disp(input logic [LINE_BITS-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        return (x > 32'h0000_FFFF) ? 16'hFFFF : x[15:0];
    endfunction

    always_comb
    begin
        w_start    = '0;
        w_start.st = st_reg;
        w_fed      = feed(w_start, byte_reg);
        w_done     = final_reg ? flush(w_fed) : w_fed;
    end

    assign line_inc      = (line_reg != '1) ? (line_reg + LINE_BITS'(1)) : line_reg;
    assign line_disp_old = line_disp(line_reg);
    assign line_disp_new = line_disp(line_inc);
    assign st_next       = final_reg ? ST_RESET : w_done.st;
    assign line_next     = final_reg ? LINE_BITS'(1) : (w_done.nl ? line_inc : line_reg);

    assign out_valid   = (cnt_reg != '0);
    assign drain       = out_valid && out_ready;
    assign last_of_run = (idx_reg == EV_IDX_BITS'(cnt_reg - EV_IDX_BITS'(1)));
    assign drain_last  = drain && last_of_run;
    assign buf_free    = !out_valid || drain_last;
    assign move        = in_valid_reg && (buf_free || (w_done.n == '0));
    assign in_ready    = !in_valid_reg || move;

    assign event_kind  = ev_reg[idx_reg[EV_IDX_BITS-1:0]].kind;
    assign event_value = ev_reg[idx_reg[EV_IDX_BITS-1:0]].value;
    assign line_number = ev_line_reg[idx_reg[EV_IDX_BITS-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= ST_RESET;
            line_reg     <= LINE_BITS'(1);
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (move)
            begin
                st_reg   <= st_next;
                line_reg <= line_next;
            end
            if (move && (w_done.n != '0))
            begin
                cnt_reg <= w_done.n;
                idx_reg <= '0;
            end
            else if (drain_last)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else if (drain)
            begin
                idx_reg <= idx_reg + EV_IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= text_byte;
            final_reg <= is_final;
        end
        if (move && (w_done.n != '0))
        begin
            for (int i = 0; i < MAX_EV; i++)
            begin
                ev_reg[i]      <= w_done.ev[i];
                ev_line_reg[i] <= w_done.ev[i].nl ? line_disp_new : line_disp_old;
            end
        end
    end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for json_token_scanner: directed table and random text.
`timescale 1ns / 1ps

module tb_top;
    import jts_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 240;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TABLE_ROWS    = 25;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  value;
        logic [15:0] line;
        logic        last;
    } lex_event_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic [3:0]  kind;
        logic [7:0]  value;
        logic [15:0] line;
    } table_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte   = 8'd0;
    logic        is_final    = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [3:0]  event_kind;
    logic [7:0]  event_value;
    logic [15:0] line_number;
    logic        last_of_run;

    logic calm = 1'b0;
    int   error_count  = 0;
    int   cycle_count  = 0;
    int   random_items = 0;

    lex_event_t expected_events[$];
    lex_event_t step_events[$];
    lex_event_t front_event;
    logic [7:0] doc_bytes[$];

    mode_t       lex_mode;
    logic [2:0]  hex_left;
    logic [7:0]  held_ch;
    logic [2:0]  kw_alive;
    logic [2:0]  word_len;
    logic        word_overflow;
    logic [15:0] line_ctr;

    string punct_set = "{}[],:";
    string ws_set    = " \t\r\n";
    string sep_set   = " ,\n";
    string esc_set   = "\"\\/bfnrt";
    string hex_set   = "0123456789abcdefABCDEF";

    table_row_t directed_rows [TABLE_ROWS] = '{
        '{CH_LBRACE,   1'b0, 1'b1, EV_LBRACE,  CODE_NONE,         16'd1},
        '{8'h00,       1'b0, 1'b1, EV_ERROR,   CODE_BAD_CHAR,     16'd1},
        '{8'hFF,       1'b0, 1'b1, EV_ERROR,   CODE_BAD_CHAR,     16'd1},
        '{CH_LF,       1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_QUOTE,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_BSLASH,   1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_LOW_U,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{"A",         1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{"x",         1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_BSLASH,   1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{"q",         1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_QUOTE,    1'b0, 1'b1, EV_STR_END, CODE_NONE,         16'd2},
        '{CH_MINUS,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{"1",         1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_DOT,      1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_DOT,      1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{"7",         1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_LOW_E,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_COMMA,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_LOW_T,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_LOW_R,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_LOW_U,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_LOW_E,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_COLON,    1'b0, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0},
        '{CH_QUOTE,    1'b1, 1'b0, EV_LBRACE,  CODE_NONE,         16'd0}
    };

    json_token_scanner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .is_final    (is_final),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .event_value (event_value),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic digit_ch(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic alpha_ch(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic string keyword_word(input int k);
        case (k)
            0:       return "true";
            1:       return "false";
            default: return "null";
        endcase
    endfunction

    task automatic doc_add(input logic [7:0] b);
        doc_bytes.insert(doc_bytes.size(), b);
    endtask

    task automatic lex_reset();
        lex_mode      = M_IDLE;
        hex_left      = 3'd0;
        held_ch       = 8'd0;
        kw_alive      = 3'b111;
        word_len      = 3'd0;
        word_overflow = 1'b0;
        line_ctr      = 16'd1;
    endtask

    task automatic lex_emit(input logic [3:0] kind, input logic [7:0] value);
        lex_event_t ev;
        ev.kind  = kind;
        ev.value = value;
        ev.line  = line_ctr;
        ev.last  = 1'b0;
        if (step_events.size() < MAX_EV)
        begin
            step_events.insert(step_events.size(), ev);
        end
    endtask

    task automatic word_push(input logic [7:0] b);
        string w;
        if (word_len >= 3'd5)
        begin
            word_overflow = 1'b1;
            kw_alive      = 3'b000;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                w = keyword_word(k);
                if ((word_len >= w.len()) || (w[word_len] != b))
                begin
                    kw_alive[k] = 1'b0;
                end
            end
        end
        if (word_len < 3'd7)
        begin
            word_len = word_len + 3'd1;
        end
    endtask

    task automatic word_close();
        string w;
        logic  matched;
        lex_mode = M_IDLE;
        matched  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            w = keyword_word(k);
            if (!matched && kw_alive[k] && !word_overflow && (word_len == w.len()))
            begin
                lex_emit(4'(EV_TRUE + k), CODE_NONE);
                matched = 1'b1;
            end
        end
        if (!matched)
        begin
            lex_emit(EV_ERROR, CODE_BAD_IDENT);
        end
    endtask

    task automatic scan_between(input logic [7:0] b);
        case (b)
            CH_LBRACE:   lex_emit(EV_LBRACE, CODE_NONE);
            CH_RBRACE:   lex_emit(EV_RBRACE, CODE_NONE);
            CH_LBRACKET: lex_emit(EV_LBRACKET, CODE_NONE);
            CH_RBRACKET: lex_emit(EV_RBRACKET, CODE_NONE);
            CH_COMMA:    lex_emit(EV_COMMA, CODE_NONE);
            CH_COLON:    lex_emit(EV_COLON, CODE_NONE);
            CH_SPACE, CH_CR, CH_TAB:
            begin
            end
            CH_LF:
            begin
                if (line_ctr != 16'hFFFF)
                begin
                    line_ctr = line_ctr + 16'd1;
                end
            end
            CH_QUOTE:    lex_mode = M_STR;
            default:
            begin
                if ((b == CH_MINUS) || digit_ch(b))
                begin
                    lex_emit(EV_NUM_CHAR, b);
                    lex_mode = M_INT;
                end
                else if (alpha_ch(b))
                begin
                    kw_alive      = 3'b111;
                    word_len      = 3'd0;
                    word_overflow = 1'b0;
                    lex_mode      = M_WORD;
                    word_push(b);
                end
                else
                begin
                    lex_emit(EV_ERROR, CODE_BAD_CHAR);
                end
            end
        endcase
    endtask

    task automatic string_char(input logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            lex_emit(EV_STR_END, CODE_NONE);
            lex_mode = M_IDLE;
        end
        else if (b == CH_BSLASH)
        begin
            lex_mode = M_ESC;
        end
        else
        begin
            lex_emit(EV_STR_BYTE, b);
        end
    endtask

    // A refused lookahead puts the held byte back between tokens, then scans b once more.
    task automatic lex_feed(input logic [7:0] b);
        logic       rescan;
        logic [7:0] h;
        logic       hex_ok;
        rescan = 1'b1;
        while (rescan)
        begin
            rescan = 1'b0;
            case (lex_mode)
                M_STR:
                begin
                    string_char(b);
                end
                M_ESC:
                begin
                    lex_mode = M_STR;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: lex_emit(EV_STR_BYTE, b);
                        CH_LOW_B: lex_emit(EV_STR_BYTE, CH_BS);
                        CH_LOW_F: lex_emit(EV_STR_BYTE, CH_FF);
                        CH_LOW_N: lex_emit(EV_STR_BYTE, CH_LF);
                        CH_LOW_T: lex_emit(EV_STR_BYTE, CH_TAB);
                        CH_LOW_R: lex_emit(EV_STR_BYTE, CH_CR);
                        CH_LOW_U:
                        begin
                            lex_mode = M_HEX;
                            hex_left = 3'd4;
                        end
                        default:
                        begin
                            lex_emit(EV_ERROR, CODE_BAD_ESCAPE);
                            lex_emit(EV_STR_BYTE, b);
                        end
                    endcase
                end
                M_HEX:
                begin
                    hex_ok = digit_ch(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
                             ((b >= 8'h41) && (b <= 8'h46));
                    if (hex_ok)
                    begin
                        if (hex_left != 3'd0)
                        begin
                            hex_left = hex_left - 3'd1;
                        end
                        if (hex_left == 3'd0)
                        begin
                            lex_emit(EV_ERROR, CODE_UTF16_IGNORE);
                            lex_mode = M_STR;
                        end
                    end
                    else
                    begin
                        lex_emit(EV_ERROR, CODE_BAD_HEX);
                        lex_emit(EV_ERROR, CODE_UTF16_IGNORE);
                        hex_left = 3'd0;
                        lex_mode = M_STR;
                        string_char(b);
                    end
                end
                M_INT, M_FRAC:
                begin
                    if (digit_ch(b))
                    begin
                        lex_emit(EV_NUM_CHAR, b);
                    end
                    else if ((b == CH_DOT) && (lex_mode == M_INT))
                    begin
                        held_ch  = b;
                        lex_mode = M_DOT;
                    end
                    else if ((b == CH_LOW_E) || (b == CH_UP_E))
                    begin
                        held_ch  = b;
                        lex_mode = M_EXPMARK;
                    end
                    else
                    begin
                        lex_emit(EV_NUM_END, CODE_NONE);
                        lex_mode = M_IDLE;
                        scan_between(b);
                    end
                end
                M_DOT, M_EXPMARK:
                begin
                    h       = held_ch;
                    held_ch = 8'd0;
                    if (digit_ch(b) ||
                        ((lex_mode == M_EXPMARK) && ((b == CH_PLUS) || (b == CH_MINUS))))
                    begin
                        lex_emit(EV_NUM_CHAR, h);
                        lex_emit(EV_NUM_CHAR, b);
                        lex_mode = (lex_mode == M_DOT) ? M_FRAC : M_EXP;
                    end
                    else
                    begin
                        lex_emit(EV_NUM_END, CODE_NONE);
                        lex_mode = M_IDLE;
                        scan_between(h);
                        rescan = 1'b1;
                    end
                end
                M_EXP:
                begin
                    if (digit_ch(b))
                    begin
                        lex_emit(EV_NUM_CHAR, b);
                    end
                    else
                    begin
                        lex_emit(EV_NUM_END, CODE_NONE);
                        lex_mode = M_IDLE;
                        scan_between(b);
                    end
                end
                M_WORD:
                begin
                    if (alpha_ch(b))
                    begin
                        word_push(b);
                    end
                    else
                    begin
                        word_close();
                        scan_between(b);
                    end
                end
                default:
                begin
                    lex_mode = M_IDLE;
                    scan_between(b);
                end
            endcase
        end
    endtask

    task automatic lex_flush();
        case (lex_mode)
            M_STR:
            begin
                lex_emit(EV_ERROR, CODE_UNTERMINATED);
            end
            M_ESC:
            begin
                lex_emit(EV_ERROR, CODE_BAD_ESCAPE);
                lex_emit(EV_ERROR, CODE_UNTERMINATED);
            end
            M_HEX:
            begin
                lex_emit(EV_ERROR, CODE_BAD_HEX);
                lex_emit(EV_ERROR, CODE_UTF16_IGNORE);
                lex_emit(EV_ERROR, CODE_UNTERMINATED);
            end
            M_INT, M_FRAC, M_EXP:
            begin
                lex_emit(EV_NUM_END, CODE_NONE);
            end
            M_DOT, M_EXPMARK:
            begin
                lex_emit(EV_NUM_END, CODE_NONE);
                lex_mode = M_IDLE;
                scan_between(held_ch);
                if (lex_mode == M_WORD)
                begin
                    word_close();
                end
            end
            M_WORD:
            begin
                word_close();
            end
            default:
            begin
            end
        endcase
        lex_emit(EV_ERROR, CODE_EOF);
    endtask

    task automatic lex_step(input logic [7:0] b, input logic fin);
        step_events.delete();
        lex_feed(b);
        if (fin)
        begin
            lex_flush();
            lex_reset();
        end
        if (step_events.size() > 0)
        begin
            step_events[step_events.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input lex_event_t typed_ev);
        while (!calm && ($urandom_range(0, 99) < 16))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        is_final  <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        lex_step(b, fin);
        if (typed)
        begin
            expected_events.insert(expected_events.size(), typed_ev);
        end
        else
        begin
            foreach (step_events[i])
            begin
                expected_events.insert(expected_events.size(), step_events[i]);
            end
        end
    endtask

    // Mostly well-formed tokens with random content; some noise and cut-off text.
    task automatic compose_document();
        int         cut;
        int         pick;
        int         digits;
        logic [7:0] c;
        string      kw;
        doc_bytes.delete();
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(0, 15))
                0, 1, 2, 15:
                begin
                    doc_add(punct_set[$urandom_range(0, 5)]);
                end
                3:
                begin
                    doc_add(ws_set[$urandom_range(0, 3)]);
                end
                4, 5, 6:
                begin
                    doc_add(CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                        begin
                            c = (pick < 4) ? 8'($urandom_range(8'h20, 8'h7E))
                                           : 8'($urandom_range(0, 255));
                            if ((c == CH_QUOTE) || (c == CH_BSLASH))
                            begin
                                c = 8'h61;
                            end
                            doc_add(c);
                        end
                        else if (pick < 8)
                        begin
                            doc_add(CH_BSLASH);
                            doc_add(esc_set[$urandom_range(0, 7)]);
                        end
                        else if (pick == 8)
                        begin
                            doc_add(CH_BSLASH);
                            doc_add(CH_LOW_U);
                            digits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
                            repeat (digits)
                            begin
                                doc_add(hex_set[$urandom_range(0, 21)]);
                            end
                        end
                        else
                        begin
                            doc_add(CH_BSLASH);
                            doc_add(8'($urandom_range(0, 255)));
                        end
                    end
                    if ($urandom_range(0, 9) != 0)
                    begin
                        doc_add(CH_QUOTE);
                    end
                end
                7, 8, 9, 14:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        doc_add(CH_MINUS);
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        doc_add(8'(8'h30 + $urandom_range(0, 9)));
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        doc_add(CH_DOT);
                        if ($urandom_range(0, 4) != 0)
                        begin
                            repeat ($urandom_range(1, 3))
                            begin
                                doc_add(8'(8'h30 + $urandom_range(0, 9)));
                            end
                        end
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        doc_add($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
                        pick = $urandom_range(0, 5);
                        if (pick == 0)
                        begin
                            doc_add(CH_PLUS);
                        end
                        else if (pick == 1)
                        begin
                            doc_add(CH_MINUS);
                        end
                        if ($urandom_range(0, 4) != 0)
                        begin
                            repeat ($urandom_range(1, 3))
                            begin
                                doc_add(8'(8'h30 + $urandom_range(0, 9)));
                            end
                        end
                    end
                end
                10, 11, 13:
                begin
                    pick = $urandom_range(0, 5);
                    if (pick < 4)
                    begin
                        kw = keyword_word($urandom_range(0, 2));
                        for (int i = 0; i < kw.len() - ((pick == 3) ? 1 : 0); i++)
                        begin
                            doc_add(kw[i]);
                        end
                    end
                    if (pick >= 3)
                    begin
                        repeat ($urandom_range(1, 7))
                        begin
                            c = 8'(8'h61 + $urandom_range(0, 25));
                            if ($urandom_range(0, 1))
                            begin
                                c = c - 8'h20;
                            end
                            doc_add(c);
                        end
                    end
                end
                default:
                begin
                    doc_add(8'($urandom_range(0, 255)));
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                doc_add(sep_set[$urandom_range(0, 2)]);
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            cut = $urandom_range(1, doc_bytes.size());
            while (doc_bytes.size() > cut)
            begin
                c = doc_bytes.pop_back();
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= rst_n && (calm || ($urandom_range(0, 99) >= 16));
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("event_kind %0d event_value %0d with no event expected",
                       event_kind, event_value);
                error_count++;
            end
            else
            begin
                front_event = expected_events.pop_front();
                if (event_kind !== front_event.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", front_event.kind, event_kind);
                    error_count++;
                end
                if (event_value !== front_event.value)
                begin
                    $error("event_value: expected %0d, got %0d",
                           front_event.value, event_value);
                    error_count++;
                end
                if (line_number !== front_event.line)
                begin
                    $error("line_number: expected %0d, got %0d",
                           front_event.line, line_number);
                    error_count++;
                end
                if (last_of_run !== front_event.last)
                begin
                    $error("last_of_run: expected %0d, got %0d",
                           front_event.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        lex_event_t typed_ev;
        int         doc_index;
        lex_reset();
        typed_ev  = '0;
        doc_index = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_ev.kind  = directed_rows[i].kind;
            typed_ev.value = directed_rows[i].value;
            typed_ev.line  = directed_rows[i].line;
            typed_ev.last  = 1'b1;
            send_byte(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
                      typed_ev);
        end

        calm <= 1'b1;
        send_byte(CH_LBRACKET, 1'b0, 1'b0, typed_ev);
        send_byte(CH_LF, 1'b1, 1'b0, typed_ev);

        while (random_items < RANDOM_ITEMS)
        begin
            compose_document();
            calm <= (doc_index >= 8) && (doc_index < 16);
            for (int i = 0; i < doc_bytes.size(); i++)
            begin
                send_byte(doc_bytes[i], i == doc_bytes.size() - 1, 1'b0, typed_ev);
                random_items++;
            end
            doc_index++;
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        while (expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/jts_pkg.sv
rtl/json_token_scanner.sv
test/tb_top.sv
